@@ rtl/core/s2l_pkg.sv @@
package s2l_pkg;

    localparam int QB     = 20;
    localparam int CH_W   = 8;
    localparam int LIN_W  = QB + 1;
    localparam int CO_W   = 24;
    localparam int PR_W   = LIN_W + CO_W;
    localparam int SUM_W  = 44;
    localparam int XYZ_W  = 21;
    localparam int WN_W   = 38;
    localparam int T_W    = 22;
    localparam int F_W    = 22;
    localparam int L_W    = 15;
    localparam int AB_W   = 16;

    typedef logic [LIN_W-1:0] t_lin_tab [256];
    typedef logic [CO_W-1:0]  t_mat [9];

    localparam t_mat MAT = '{
        24'd4124564, 24'd3575761, 24'd1804375,
        24'd2126729, 24'd7151522, 24'd721750,
        24'd193339,  24'd1191920, 24'd9503041
    };

    localparam longint unsigned MAT_D   = 64'd10000000;
    localparam longint unsigned MAT_RND = 64'd5000000;
    localparam longint unsigned WP_MUL  = 64'd100000;
    localparam longint unsigned WX_RND  = 64'd47523;
    localparam longint unsigned WX_D    = 64'd95047;
    localparam longint unsigned WZ_RND  = 64'd54441;
    localparam longint unsigned WZ_D    = 64'd108883;

    localparam longint unsigned LIN_THR   = (64'd8856 << QB) / 64'd1000000;
    localparam longint unsigned LIN_OFS   = ((64'd16 << QB) + 64'd58) / 64'd116;
    localparam longint unsigned F_LIN_MUL = 64'd7787;
    localparam longint unsigned F_LIN_RND = 64'd500;
    localparam longint unsigned F_LIN_D   = 64'd1000;

    localparam longint unsigned L_MUL = 64'd116;
    localparam longint unsigned A_MUL = 64'd500;
    localparam longint unsigned B_MUL = 64'd200;
    localparam longint unsigned L_OFS = 64'd16 << QB;

    function automatic longint unsigned pow5_q(input longint unsigned r);
        longint unsigned p;
        p = (r * r) >> QB;
        p = (p * p) >> QB;
        return (p * r) >> QB;
    endfunction

    function automatic t_lin_tab build_lin_tab();
        t_lin_tab        tab;
        longint unsigned c;
        longint unsigned base;
        longint unsigned s;
        longint unsigned r;
        longint unsigned cand;
        for (int i = 0; i < 256; i++) begin
            c = 64'(i);
            if (c <= 64'd10) begin
                tab[i] = LIN_W'((c * 64'd104857600 + 64'd164730) / 64'd329460);
            end else begin
                base = ((c * 64'd1000 + 64'd14025) * (64'd1 << QB) + 64'd134512)
                       / 64'd269025;
                s = (base * base + (64'd1 << (QB - 1))) >> QB;
                r = 64'd0;
                for (int bi = QB; bi >= 0; bi--) begin
                    cand = r | (64'd1 << bi);
                    if (cand <= (64'd1 << QB) && pow5_q(cand) <= s) begin
                        r = cand;
                    end
                end
                tab[i] = LIN_W'((s * r + (64'd1 << (QB - 1))) >> QB);
            end
        end
        return tab;
    endfunction

    localparam t_lin_tab LIN_TAB = build_lin_tab();

endpackage

@@ rtl/core/s2l_if.sv @@
interface s2l_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface s2l_out_if;
    logic               valid;
    logic               ready;
    logic        [14:0] lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;

    modport source (output valid, output lightness, output green_red,
                    output blue_yellow, input ready);
    modport sink   (input valid, input lightness, input green_red,
                    input blue_yellow, output ready);
endinterface

@@ rtl/core/s2l_cdiv.sv @@
module s2l_cdiv #(
    parameter int              NW = 44,
    parameter int              QW = 21,
    parameter longint unsigned D  = 64'd10000000
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    output logic [QW-1:0] o_quo
);
    localparam int              HW = 24;
    localparam int              SH = NW - HW;
    localparam longint unsigned M  = (64'd1 << (SH + HW)) / D;
    localparam int              MW = $clog2(M + 1);
    localparam int              DW = $clog2(D) + 3;
    localparam int              PW = HW + MW;

    logic [NW-1:0] r_num;
    logic [QW-1:0] r_q0;
    logic [QW-1:0] r_q1;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_quo;

    logic [PW-1:0] n_prod;
    logic [QW-1:0] n_q0;
    logic [DW-1:0] n_back;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_quo;

    assign n_prod = PW'(i_num[NW-1:SH]) * PW'(M);
    assign n_q0   = QW'(n_prod >> HW);
    assign n_back = DW'(r_q0) * DW'(D);
    assign n_rem  = DW'(r_num) - n_back;
    assign n_quo  = r_q1 + QW'(r_rem >= DW'(D)) + QW'(r_rem >= DW'(2 * D))
                    + QW'(r_rem >= DW'(3 * D));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= i_num;
            r_q0  <= n_q0;
            r_q1  <= r_q0;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

@@ rtl/core/s2l_cief.sv @@
module s2l_cief (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [s2l_pkg::T_W-1:0] i_t,
    output logic [s2l_pkg::F_W-1:0] o_f
);
    import s2l_pkg::*;

    localparam int STEPS = QB + 1;
    localparam int CW    = 66;
    localparam int Y2_W  = 44;
    localparam int LN_W  = 27;
    localparam int LQ_W  = 17;
    localparam int LD    = STEPS - 3;

    logic [F_W-1:0]  r_y  [STEPS+1];
    logic [Y2_W-1:0] r_y2 [STEPS+1];
    logic [CW-1:0]   r_y3 [STEPS+1];
    logic [CW-1:0]   r_tg [STEPS+1];
    logic            r_lf [STEPS+1];
    logic [LN_W-1:0] r_lnum;
    logic [LQ_W-1:0] r_ld [LD];
    logic [F_W-1:0]  r_f;
    logic [LQ_W-1:0] lin_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y[0]  <= '0;
            r_y2[0] <= '0;
            r_y3[0] <= '0;
            r_tg[0] <= CW'(i_t) << 40;
            r_lf[0] <= i_t <= T_W'(LIN_THR);
            r_lnum  <= LN_W'(LN_W'(i_t) * LN_W'(F_LIN_MUL) + LN_W'(F_LIN_RND));
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int B = QB - k;
        logic [CW-1:0] n_c3;
        logic          n_take;

        assign n_c3 = r_y3[k] + ((CW'(r_y2[k]) * 3) << B)
                      + ((CW'(r_y[k]) * 3) << (2 * B)) + (CW'(1) << (3 * B));
        assign n_take = n_c3 <= r_tg[k];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tg[k+1] <= r_tg[k];
                r_lf[k+1] <= r_lf[k];
                if (n_take) begin
                    r_y[k+1]  <= r_y[k] | (F_W'(1) << B);
                    r_y2[k+1] <= r_y2[k] + (Y2_W'(r_y[k]) << (B + 1))
                                 + (Y2_W'(1) << (2 * B));
                    r_y3[k+1] <= n_c3;
                end else begin
                    r_y[k+1]  <= r_y[k];
                    r_y2[k+1] <= r_y2[k];
                    r_y3[k+1] <= r_y3[k];
                end
            end
        end
    end

    s2l_cdiv #(
        .NW (LN_W),
        .QW (LQ_W),
        .D  (F_LIN_D)
    ) u_lin_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_lnum),
        .o_quo (lin_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ld[0] <= lin_q;
            for (int i = 1; i < LD; i++) begin
                r_ld[i] <= r_ld[i-1];
            end
            if (r_lf[STEPS]) begin
                r_f <= F_W'(r_ld[LD-1]) + F_W'(LIN_OFS);
            end else begin
                r_f <= r_y[STEPS];
            end
        end
    end

    assign o_f = r_f;

endmodule

@@ rtl/core/srgb_to_cielab_pixel.sv @@
// sRGB to CIELAB (D65) pixel converter.
//
// Input channel i_pix carries one 8-bit red, green, blue pixel per request;
// output channel o_lab carries L*, a* and b* scaled by 2^FRAC_BITS, rounded
// and saturated. Both channels use valid/ready; a request moves when both
// are high. Every pixel gives exactly one result.
//
// Throughput is one pixel per cycle while the output is not stalled: the
// pipeline is 35 register stages deep (table lookup, matrix products, two
// constant-divider ranks, a 21-stage cube root and the output scaler),
// with a valid bit traveling beside each stage.
//
// When o_lab.ready is low while a result is held, the whole pipeline holds,
// bubbles included, and i_pix.ready drops; with no result held it advances
// whatever o_lab.ready is. Synchronous active-low reset clears all valid
// bits; the payload registers are not reset.
module srgb_to_cielab_pixel #(
    parameter int FRAC_BITS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    s2l_in_if.sink   i_pix,
    s2l_out_if.source o_lab
);
    import s2l_pkg::*;

    localparam int LAT = 35;
    localparam int SH  = QB - FRAC_BITS;
    localparam int V_W = 34;

    localparam logic signed [V_W-1:0] L_MAX  = V_W'(32767);
    localparam logic signed [V_W-1:0] AB_MAX = V_W'(32767);
    localparam logic signed [V_W-1:0] AB_MIN = -V_W'(32768);

    logic               adv;
    logic [LAT-1:0]     r_vld;
    logic [LIN_W-1:0]   r_lin [3];
    logic [PR_W-1:0]    r_prod [9];
    logic [SUM_W-1:0]   r_sum [3];
    logic [XYZ_W-1:0]   q_xyz [3];
    logic [WN_W-1:0]    r_wx;
    logic [WN_W-1:0]    r_wz;
    logic [XYZ_W-1:0]   r_ydly [4];
    logic [T_W-1:0]     wq_x;
    logic [T_W-1:0]     wq_z;
    logic [F_W-1:0]     f_x;
    logic [F_W-1:0]     f_y;
    logic [F_W-1:0]     f_z;
    logic signed [V_W-1:0] r_lv;
    logic signed [V_W-1:0] r_av;
    logic signed [V_W-1:0] r_bv;
    logic signed [V_W-1:0] n_ls;
    logic signed [V_W-1:0] n_as;
    logic signed [V_W-1:0] n_bs;
    logic [L_W-1:0]     r_l;
    logic [AB_W-1:0]    r_a;
    logic [AB_W-1:0]    r_b;

    function automatic logic signed [V_W-1:0] scale_out(input logic signed [V_W-1:0] v);
        logic [V_W-1:0] mag;
        logic [V_W-1:0] rnd;
        mag = v[V_W-1] ? V_W'(-v) : V_W'(v);
        rnd = (mag + (V_W'(1) << (SH - 1))) >> SH;
        return v[V_W-1] ? -$signed(rnd) : $signed(rnd);
    endfunction

    assign adv         = !r_vld[LAT-1] || o_lab.ready;
    assign i_pix.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_pix.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lin[0] <= LIN_TAB[i_pix.red];
            r_lin[1] <= LIN_TAB[i_pix.green];
            r_lin[2] <= LIN_TAB[i_pix.blue];
            for (int i = 0; i < 9; i++) begin
                r_prod[i] <= PR_W'(r_lin[i % 3]) * PR_W'(MAT[i]);
            end
            for (int j = 0; j < 3; j++) begin
                r_sum[j] <= SUM_W'(r_prod[3 * j] + r_prod[3 * j + 1] + r_prod[3 * j + 2]
                                   + PR_W'(MAT_RND));
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_mat_div
        s2l_cdiv #(
            .NW (SUM_W),
            .QW (XYZ_W),
            .D  (MAT_D)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (r_sum[j]),
            .o_quo (q_xyz[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wx      <= WN_W'(q_xyz[0]) * WN_W'(WP_MUL) + WN_W'(WX_RND);
            r_wz      <= WN_W'(q_xyz[2]) * WN_W'(WP_MUL) + WN_W'(WZ_RND);
            r_ydly[0] <= q_xyz[1];
            for (int i = 1; i < 4; i++) begin
                r_ydly[i] <= r_ydly[i-1];
            end
        end
    end

    s2l_cdiv #(
        .NW (WN_W),
        .QW (T_W),
        .D  (WX_D)
    ) u_wx_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_wx),
        .o_quo (wq_x)
    );

    s2l_cdiv #(
        .NW (WN_W),
        .QW (T_W),
        .D  (WZ_D)
    ) u_wz_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_wz),
        .o_quo (wq_z)
    );

    s2l_cief u_fx (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_t   (wq_x),
        .o_f   (f_x)
    );

    s2l_cief u_fy (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_t   (T_W'(r_ydly[3])),
        .o_f   (f_y)
    );

    s2l_cief u_fz (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_t   (wq_z),
        .o_f   (f_z)
    );

    assign n_ls = scale_out(r_lv);
    assign n_as = scale_out(r_av);
    assign n_bs = scale_out(r_bv);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lv <= $signed(V_W'(f_y)) * $signed(V_W'(L_MUL)) - $signed(V_W'(L_OFS));
            r_av <= ($signed(V_W'(f_x)) - $signed(V_W'(f_y))) * $signed(V_W'(A_MUL));
            r_bv <= ($signed(V_W'(f_y)) - $signed(V_W'(f_z))) * $signed(V_W'(B_MUL));

            if (n_ls < 0) begin
                r_l <= '0;
            end else if (n_ls > L_MAX) begin
                r_l <= L_W'(L_MAX);
            end else begin
                r_l <= L_W'(n_ls);
            end

            if (n_as < AB_MIN) begin
                r_a <= AB_W'(AB_MIN);
            end else if (n_as > AB_MAX) begin
                r_a <= AB_W'(AB_MAX);
            end else begin
                r_a <= AB_W'(n_as);
            end

            if (n_bs < AB_MIN) begin
                r_b <= AB_W'(AB_MIN);
            end else if (n_bs > AB_MAX) begin
                r_b <= AB_W'(AB_MAX);
            end else begin
                r_b <= AB_W'(n_bs);
            end
        end
    end

    assign o_lab.valid       = r_vld[LAT-1];
    assign o_lab.lightness   = r_l;
    assign o_lab.green_red   = $signed(r_a);
    assign o_lab.blue_yellow = $signed(r_b);

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("valid pipeline moved during stall");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("valid pipeline not cleared by reset");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_vld[0])
        else $error("accepted request did not enter pipeline");

    a_drain_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_lab.valid && o_lab.ready) |-> i_pix.ready)
        else $error("input blocked while output drains");

endmodule
